// ===== design/a64ps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64ps_pkg
// Shared constants, decode struct and helpers for the AArch64 argument
// register scanner.
// ----------------------------------------------------------------------------
package a64ps_pkg;

  localparam int PROLOGUE_WORDS_DEF = 64;
  localparam int LOOKBACK_WORDS_DEF = 4;

  localparam int WORD_W  = 32;
  localparam int MASK_W  = 8;
  localparam int COUNT_W = 4;

  // Opcode masks and match values
  localparam logic [WORD_W-1:0] STP_SP_MASK  = 32'hFFC0_03FF;
  localparam logic [WORD_W-1:0] STP_SP_MATCH = 32'hF900_03FF;
  localparam logic [WORD_W-1:0] LDR_MASK     = 32'hFFC0_0000;
  localparam logic [WORD_W-1:0] LDR_MATCH    = 32'hF940_0000;
  localparam logic [WORD_W-1:0] ADDI_MASK    = 32'hFF80_0000;
  localparam logic [WORD_W-1:0] ADDI_MATCH   = 32'h9100_0000;
  localparam logic [WORD_W-1:0] BL_MASK      = 32'hFC00_0000;
  localparam logic [WORD_W-1:0] BL_MATCH     = 32'h9400_0000;
  localparam logic [WORD_W-1:0] MOVZ_MASK    = 32'h7F80_0000;
  localparam logic [WORD_W-1:0] MOVZ_MATCH   = 32'h5280_0000;
  localparam logic [WORD_W-1:0] MOVR_MASK    = 32'hFFE0_03E0;
  localparam logic [WORD_W-1:0] MOVR_MATCH   = 32'hAA00_03E0;

  // Per-word decode results
  typedef struct packed {
    logic              stack_store;
    logic              is_bl;
    logic [MASK_W-1:0] pro_onehot;
    logic [MASK_W-1:0] mov_onehot;
  } dec_t;

  // One-hot of a register number, zero for anything above x7
  function automatic logic [MASK_W-1:0] reg_onehot(input logic [4:0] reg_num);
    logic [MASK_W-1:0] oh;
    oh = '0;
    if (reg_num[4:3] == 2'b00) begin
      oh[reg_num[2:0]] = 1'b1;
    end
    return oh;
  endfunction

  function automatic logic [COUNT_W-1:0] popcount8(input logic [MASK_W-1:0] v);
    logic [COUNT_W-1:0] cnt;
    cnt = '0;
    for (int i = 0; i < MASK_W; i++) begin
      cnt = cnt + COUNT_W'(v[i]);
    end
    return cnt;
  endfunction

endpackage

// ===== design/a64ps_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64ps_in_if
// Instruction word channel: valid/ready with word and function markers.
// ----------------------------------------------------------------------------
interface a64ps_in_if;
  logic                          valid;
  logic                          ready;
  logic [a64ps_pkg::WORD_W-1:0]  instr_word;
  logic                          first_word;
  logic                          last_word;

  modport source (output valid, output instr_word, output first_word,
                  output last_word, input ready);
  modport sink   (input valid, input instr_word, input first_word,
                  input last_word, output ready);
endinterface

// ===== design/a64ps_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64ps_out_if
// Result channel: valid/ready with register mask and its population count.
// ----------------------------------------------------------------------------
interface a64ps_out_if;
  logic                          valid;
  logic                          ready;
  logic [a64ps_pkg::MASK_W-1:0]  param_mask;
  logic [a64ps_pkg::COUNT_W-1:0] param_count;

  modport source (output valid, output param_mask, output param_count,
                  input ready);
  modport sink   (input valid, input param_mask, input param_count,
                  output ready);
endinterface

// ===== design/a64ps_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64ps_decode
// Classify one instruction word: stack store, prologue load/add, BL, moves.
// ----------------------------------------------------------------------------
module a64ps_decode (
  input  logic [a64ps_pkg::WORD_W-1:0] instr_word,
  output a64ps_pkg::dec_t              dec
);

  logic       base_arg;
  logic       ldr_add;
  logic       is_mov;
  logic [4:0] rd;

  assign rd       = instr_word[4:0];
  assign base_arg = (instr_word[9:8] == 2'b00);  // Rn in x0-x7
  assign ldr_add  = ((instr_word & a64ps_pkg::LDR_MASK) == a64ps_pkg::LDR_MATCH) ||
                    ((instr_word & a64ps_pkg::ADDI_MASK) == a64ps_pkg::ADDI_MATCH);
  assign is_mov   = ((instr_word & a64ps_pkg::MOVZ_MASK) == a64ps_pkg::MOVZ_MATCH) ||
                    ((instr_word & a64ps_pkg::MOVR_MASK) == a64ps_pkg::MOVR_MATCH);

  always_comb begin
    dec.stack_store = ((instr_word & a64ps_pkg::STP_SP_MASK) == a64ps_pkg::STP_SP_MATCH);
    dec.is_bl       = ((instr_word & a64ps_pkg::BL_MASK) == a64ps_pkg::BL_MATCH);
    dec.pro_onehot  = (ldr_add && base_arg) ? a64ps_pkg::reg_onehot(rd) : '0;
    dec.mov_onehot  = is_mov ? a64ps_pkg::reg_onehot(rd) : '0;
  end

endmodule

// ===== design/a64ps_win_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64ps_win_cell
// One lookback slot: holds a move-destination one-hot, passes it on to the
// next slot on each accepted word and folds it into the running OR chain.
// ----------------------------------------------------------------------------
module a64ps_win_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  logic                          kill,
  input  logic [a64ps_pkg::MASK_W-1:0]  entry_in,
  input  logic [a64ps_pkg::MASK_W-1:0]  or_in,
  output logic [a64ps_pkg::MASK_W-1:0]  entry_out,
  output logic [a64ps_pkg::MASK_W-1:0]  or_out
);

  logic [a64ps_pkg::MASK_W-1:0] entry_r;
  logic [a64ps_pkg::MASK_W-1:0] entry_nxt;

  // Drop the neighbor's entry when a new function starts
  assign entry_nxt = kill ? '0 : entry_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else if (advance) begin
      entry_r <= entry_nxt;
    end
  end

  assign entry_out = entry_r;
  assign or_out    = or_in | entry_r;

endmodule

// ===== design/arm64_param_register_scan_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm64_param_register_scan_core
// Scans the instruction words of one AArch64 function and reports which of
// the argument registers x0-x7 it treats as parameters.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                              Transaction when
//  in_ch    in   instr_word[31:0] first_word last_word  valid && ready
//  out_ch   out  param_mask[7:0] param_count[3:0]     valid && ready
//
//  One word per cycle, back to back while in_ch.ready is high; a result
//  appears the cycle after the transaction carrying last_word and sits in
//  the output register. Throughput is set by the output register:
//  in_ch.ready drops only while a result is held and out_ch.ready is low.
//  rst_n is synchronous, active low; it clears mask, counters and window.
// ----------------------------------------------------------------------------
module arm64_param_register_scan_core #(
  parameter int PROLOGUE_WORDS = a64ps_pkg::PROLOGUE_WORDS_DEF,
  parameter int LOOKBACK_WORDS = a64ps_pkg::LOOKBACK_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  a64ps_in_if.sink           in_ch,
  a64ps_out_if.source        out_ch
);

  localparam int IDX_W  = $clog2(PROLOGUE_WORDS + 1);
  localparam int MASK_W = a64ps_pkg::MASK_W;

  // Handshake
  logic accept;

  // Scan state
  logic [MASK_W-1:0] found_r,  found_nxt;
  logic              done_r,   done_nxt;
  logic [IDX_W-1:0]  idx_r,    idx_nxt;

  // Output register
  logic                          out_valid_r;
  logic [MASK_W-1:0]             out_mask_r;
  logic [a64ps_pkg::COUNT_W-1:0] out_count_r;

  // Decode and window
  a64ps_pkg::dec_t   dec;
  logic [MASK_W-1:0] win_entry [LOOKBACK_WORDS];
  logic [MASK_W-1:0] win_or    [LOOKBACK_WORDS+1];

  // Effective state for this word: a first word starts from the reset state
  logic [MASK_W-1:0] found_base;
  logic              done_base;
  logic [IDX_W-1:0]  idx_base;
  logic              in_prologue;
  logic              idx_open;

  // Accept whenever the output slot is free or being drained this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  a64ps_decode u_decode (
    .instr_word (in_ch.instr_word),
    .dec        (dec)
  );

  // Lookback window: a row of cells, newest word in cell 0. The OR chain
  // runs through every cell and gives the union of all move destinations in the window.
  assign win_or[0] = '0;

  for (genvar i = 0; i < LOOKBACK_WORDS; i++) begin : g_win
    if (i == 0) begin : g_head
      a64ps_win_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (accept),
        .kill      (1'b0),
        .entry_in  (dec.mov_onehot),
        .or_in     (win_or[i]),
        .entry_out (win_entry[i]),
        .or_out    (win_or[i+1])
      );
    end else begin : g_body
      a64ps_win_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (accept),
        .kill      (in_ch.first_word),
        .entry_in  (win_entry[i-1]),
        .or_in     (win_or[i]),
        .entry_out (win_entry[i]),
        .or_out    (win_or[i+1])
      );
    end
  end

  always_comb begin
    found_base  = in_ch.first_word ? '0   : found_r;
    done_base   = in_ch.first_word ? 1'b0 : done_r;
    idx_base    = in_ch.first_word ? '0   : idx_r;
    idx_open    = (idx_base < IDX_W'(PROLOGUE_WORDS));
    in_prologue = !done_base && idx_open;

    found_nxt = found_base;
    // Prologue: mark loads/adds from argument registers until the stack store or PROLOGUE_WORDS words
    if (in_prologue && !dec.stack_store) begin
      found_nxt = found_nxt | dec.pro_onehot;
    end
    // Call site: pull in the recent moves, but not across a function start
    if (dec.is_bl && !in_ch.first_word) begin
      found_nxt = found_nxt | win_or[LOOKBACK_WORDS];
    end

    done_nxt = done_base || (in_prologue && dec.stack_store);
    // Saturate the word counter at the prologue length
    idx_nxt  = idx_open ? idx_base + IDX_W'(1) : idx_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= '0;
      done_r  <= 1'b0;
      idx_r   <= '0;
    end else if (accept) begin
      found_r <= found_nxt;
      done_r  <= done_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && in_ch.last_word) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.last_word) begin
      out_mask_r  <= found_nxt;
      out_count_r <= a64ps_pkg::popcount8(found_nxt);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.param_mask  = out_mask_r;
  assign out_ch.param_count = out_count_r;

endmodule

// ===== design/a64ps_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64ps_checker
// Port-level checks for the argument register scanner, bound to the top.
// ----------------------------------------------------------------------------
module a64ps_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_last_word,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [a64ps_pkg::MASK_W-1:0]  out_param_mask,
  input logic [a64ps_pkg::COUNT_W-1:0] out_param_count
);

  // Count always matches the mask it travels with
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones(out_param_mask) == 32'(out_param_count)))
    else $error("param_count does not match param_mask");

  // A last word yields a result in the next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_word) |=> out_valid)
    else $error("no result after last word");

  // A result only appears after a last word was taken
  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last_word))
    else $error("result without last word");

  // A held, unaccepted result blocks new words
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while result stalled");

  // Stalled result holds its payload
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_param_mask)
                                   && $stable(out_param_count)))
    else $error("stalled result changed");

endmodule

bind arm64_param_register_scan_core a64ps_checker u_a64ps_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_last_word    (in_ch.last_word),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_param_mask  (out_ch.param_mask),
  .out_param_count (out_ch.param_count)
);
